// ----- rtl/core/synth_voice_allocator_core_macros.svh -----
// ---------------------------------------------------------------------------
// Voice allocator assertion macros
// Shorthand for the concurrent checks of the voice allocator core.
// ---------------------------------------------------------------------------
`ifndef SYNTH_VOICE_ALLOCATOR_CORE_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_CORE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define SVA_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SVA_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SVA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/svalloc_pkg.sv -----
// ---------------------------------------------------------------------------
// Voice allocator package
// Pool size, derived widths, operation and status codes, stream widths.
// ---------------------------------------------------------------------------
package svalloc_pkg;

	localparam int VOICE_COUNT = 16;

	// Width of a voice index and of a count that can hold the pool size.
	localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int CNT_W  = $clog2(VOICE_COUNT + 1);

	localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);

	localparam int SEL_W     = 4;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 80;

	typedef enum logic [1:0] {
		OP_ACTIVATE = 2'd0,
		OP_RELEASE  = 2'd1,
		OP_FREE     = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK              = 2'd0,
		ST_NO_FREE         = 2'd1,
		ST_NONE_RELEASABLE = 2'd2,
		ST_NOT_ALLOCATED   = 2'd3
	} status_t;

endpackage

// ----- rtl/core/synth_voice_allocator_core.sv -----
// ---------------------------------------------------------------------------
// Synthesizer voice allocator core
// Oldest-first voice pool with a linked allocation-order list.
// ---------------------------------------------------------------------------
// The block takes one command beat, works on it alone and returns exactly one
// result beat. A single cursor register steps through the pool or along the
// allocation-order links, one voice per cycle, and all list updates go through
// one link write per cycle. Activate scans up from voice 0 to the lowest free
// voice, or through the whole pool when it is full. Release walks the list from
// the oldest voice to the oldest voice not yet releasing, at most active_count
// voices. Free walks nothing when the named voice is oldest or not allocated,
// and walks from the oldest voice to find its predecessor otherwise. No
// clearing pass is needed after reset. A new command is taken while the
// previous result still waits on the output.
// ---------------------------------------------------------------------------
`include "synth_voice_allocator_core_macros.svh"

module synth_voice_allocator_core
	import svalloc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// voice_sel[3:0], note_freq[35:4], envelope_word[67:36], zero[71:68]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// voice_index[3:0], start_voice[4], release_voice[5], out_freq[37:6],
	// out_envelope[69:38], active_count[74:70], zero[79:75]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [1:0]            m_tuser
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WALK,
		S_FREE_CHK,
		S_FIND,
		S_FREE_END,
		S_FINISH
	} state_t;

	state_t               state_q;
	logic [VOICE_COUNT-1:0] busy_q;
	logic [VOICE_COUNT-1:0] rel_q;
	logic [VIDX_W-1:0]    next_q [VOICE_COUNT];
	logic [VIDX_W-1:0]    head_q;
	logic [VIDX_W-1:0]    tail_q;
	logic [CNT_W-1:0]     count_q;

	logic [VIDX_W-1:0]    p_q;
	logic [CNT_W-1:0]     n_q;
	logic [VIDX_W-1:0]    link_q;
	logic [SEL_W-1:0]     sel_q;
	logic [31:0]          freq_q;
	logic [31:0]          env_q;

	status_t              res_status_q;
	logic [3:0]           res_idx_q;
	logic                 res_start_q;
	logic                 res_rel_q;

	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]           m_tuser_q;

	logic [VIDX_W-1:0]    link_rd;
	logic [VIDX_W-1:0]    sel_idx;
	logic                 sel_in_pool;
	logic                 out_free;

	// One read port on the link table, addressed by the cursor.
	assign link_rd     = next_q[p_q];
	assign sel_idx     = VIDX_W'(sel_q);
	assign sel_in_pool = (32'(sel_q) < 32'(VOICE_COUNT));
	assign out_free    = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			busy_q       <= '0;
			rel_q        <= '0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				next_q[i] <= '0;
			end
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			p_q          <= '0;
			n_q          <= '0;
			m_tvalid_q   <= 1'b0;
			res_status_q <= ST_OK;
			res_idx_q    <= '0;
			res_start_q  <= 1'b0;
			res_rel_q    <= 1'b0;
		end else begin
			// The finish state loads the next beat itself when the output frees up.
			if (m_tvalid_q && m_tready && (state_q != S_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						sel_q        <= s_tdata[3:0];
						freq_q       <= s_tdata[35:4];
						env_q        <= s_tdata[67:36];
						res_status_q <= ST_OK;
						res_idx_q    <= '0;
						res_start_q  <= 1'b0;
						res_rel_q    <= 1'b0;
						n_q          <= '0;
						unique case (s_tuser)
							OP_ACTIVATE: begin
								p_q     <= '0;
								state_q <= S_SCAN;
							end
							OP_RELEASE: begin
								p_q     <= head_q;
								state_q <= S_WALK;
							end
							OP_FREE: begin
								p_q     <= VIDX_W'(s_tdata[3:0]);
								state_q <= S_FREE_CHK;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end

				S_SCAN: begin
					if (!busy_q[p_q]) begin
						busy_q[p_q] <= 1'b1;
						rel_q[p_q]  <= 1'b0;
						// A free voice already has a cleared link, so only the
						// old tail needs its link written.
						if (count_q == '0) begin
							head_q <= p_q;
						end else begin
							next_q[tail_q] <= p_q;
						end
						tail_q       <= p_q;
						count_q      <= count_q + 1'b1;
						res_idx_q    <= 4'(p_q);
						res_start_q  <= 1'b1;
						state_q      <= S_FINISH;
					end else if (p_q == LAST_VOICE) begin
						res_status_q <= ST_NO_FREE;
						state_q      <= S_FINISH;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end

				S_WALK: begin
					if (n_q == count_q) begin
						res_status_q <= ST_NONE_RELEASABLE;
						state_q      <= S_FINISH;
					end else if (!rel_q[p_q]) begin
						rel_q[p_q] <= 1'b1;
						res_idx_q  <= 4'(p_q);
						res_rel_q  <= 1'b1;
						state_q    <= S_FINISH;
					end else begin
						p_q <= link_rd;
						n_q <= n_q + 1'b1;
					end
				end

				S_FREE_CHK: begin
					res_idx_q <= sel_q;
					if (!sel_in_pool || !busy_q[p_q]) begin
						res_status_q <= ST_NOT_ALLOCATED;
						state_q      <= S_FINISH;
					end else begin
						link_q      <= link_rd;
						next_q[p_q] <= '0;
						busy_q[p_q] <= 1'b0;
						rel_q[p_q]  <= 1'b0;
						if (head_q == p_q) begin
							head_q  <= link_rd;
							state_q <= S_FREE_END;
						end else begin
							p_q     <= head_q;
							state_q <= S_FIND;
						end
					end
				end

				S_FIND: begin
					// Walk from the oldest voice until the one that links to
					// the freed voice, then splice the freed voice out.
					if (link_rd == sel_idx) begin
						next_q[p_q] <= link_q;
						if (tail_q == sel_idx) begin
							tail_q <= p_q;
						end
						state_q <= S_FREE_END;
					end else begin
						p_q <= link_rd;
					end
				end

				S_FREE_END: begin
					count_q <= count_q - 1'b1;
					if (count_q == CNT_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end
					state_q <= S_FINISH;
				end

				S_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= res_status_q;
						m_tdata_q  <= {5'b0, 5'(count_q),
							res_start_q ? env_q : 32'd0,
							res_start_q ? freq_q : 32'd0,
							res_rel_q, res_start_q, res_idx_q};
						state_q    <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SVA_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready while still working")
	`SVA_IMPLY(a_count_matches_pool, state_q == S_IDLE, $countones(busy_q) == count_q,
		"voice count differs from busy voices")
	`SVA_ALWAYS(a_release_only_busy, (rel_q & ~busy_q) == '0, "releasing mark on a free voice")
	`SVA_IMPLY(a_result_from_finish, $rose(m_tvalid), $past(state_q == S_FINISH),
		"result beat without a finished command")
	`SVA_IMPLY(a_start_or_release, m_tvalid, !(m_tdata[4] && m_tdata[5]),
		"start and release in the same beat")

endmodule
